// ===== rtl/mbht_pkg.sv =====
// mbht_pkg: shared types and constants of the bonded host table
// entry layout, command codes, transport codes and cell control struct
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package mbht_pkg;

	localparam int DEF_TABLE_DEPTH = 8;
	localparam int ADDR_W          = 48;
	localparam int FLAG_W          = 16;
	localparam int TOTAL_W         = 4;

	typedef enum logic [2:0] {
		CMD_SET_KEY     = 3'd0,
		CMD_SET_FLAGS   = 3'd1,
		CMD_GET_FLAGS   = 3'd2,
		CMD_REMOVE_ACT  = 3'd3,
		CMD_REMOVE_ADDR = 3'd4,
		CMD_REMOVE_ALL  = 3'd5,
		CMD_QUERY       = 3'd6
	} cmd_code_t;

	localparam logic [1:0] TR_NONE  = 2'd0;
	localparam logic [1:0] TR_BREDR = 2'd1;
	localparam logic [1:0] TR_LE    = 2'd2;

	typedef struct packed {
		logic [ADDR_W-1:0] addr;
		logic [1:0]        tr;
		logic [1:0]        at;
		logic [FLAG_W-1:0] nf;
		logic [FLAG_W-1:0] inf;
	} ent_t;

	// broadcast to every cell in the update cycle
	typedef struct packed {
		logic en;
		logic act;
		logic hit;
		logic full;
		logic drop_top;
		logic drop_hit;
		logic clear_all;
	} cell_ctl_t;

endpackage

`default_nettype wire

// ===== rtl/mbht_cmd_if.sv =====
// mbht_cmd_if: command channel of the bonded host table
// valid/ready handshake with the command payload, widths from mbht_pkg
`timescale 1ns / 1ps
`default_nettype none

interface mbht_cmd_if;
	import mbht_pkg::*;

	logic              valid;
	logic              ready;
	logic [2:0]        command;
	logic [ADDR_W-1:0] peer_address;
	logic              has_key;
	logic [1:0]        link_transport;
	logic [1:0]        peer_addr_type;
	logic [FLAG_W-1:0] notify_flags_in;
	logic [FLAG_W-1:0] indicate_flags_in;

	modport source (
		output valid, command, peer_address, has_key, link_transport, peer_addr_type,
		output notify_flags_in, indicate_flags_in,
		input  ready
	);

	modport sink (
		input  valid, command, peer_address, has_key, link_transport, peer_addr_type,
		input  notify_flags_in, indicate_flags_in,
		output ready
	);

endinterface

`default_nettype wire

// ===== rtl/mbht_rsp_if.sv =====
// mbht_rsp_if: result channel of the bonded host table
// valid/ready handshake with the result payload, widths from mbht_pkg
`timescale 1ns / 1ps
`default_nettype none

interface mbht_rsp_if;
	import mbht_pkg::*;

	logic               valid;
	logic               ready;
	logic               was_present;
	logic               top_changed;
	logic               op_ok;
	logic [FLAG_W-1:0]  notify_flags_out;
	logic [FLAG_W-1:0]  indicate_flags_out;
	logic [TOTAL_W-1:0] entry_total;
	logic [ADDR_W-1:0]  active_address;
	logic [1:0]         active_transport;
	logic [1:0]         active_addr_type;

	modport source (
		output valid, was_present, top_changed, op_ok, notify_flags_out,
		output indicate_flags_out, entry_total, active_address, active_transport,
		output active_addr_type,
		input  ready
	);

	modport sink (
		input  valid, was_present, top_changed, op_ok, notify_flags_out,
		input  indicate_flags_out, entry_total, active_address, active_transport,
		input  active_addr_type,
		output ready
	);

endinterface

`default_nettype wire

// ===== rtl/mbht_cell.sv =====
// mbht_cell: one slot of the move-to-front chain
// holds an entry and its valid bit, compares the address, shifts up or down
// depends on mbht_pkg
`timescale 1ns / 1ps
`default_nettype none

module mbht_cell #(
	parameter int IDX = 0
) (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          cmp_load,
	input  wire [mbht_pkg::ADDR_W-1:0]   cmp_addr,
	input  mbht_pkg::cell_ctl_t          ctl,
	input  mbht_pkg::ent_t               head,
	input  mbht_pkg::ent_t               up_ent,
	input  wire                          up_vld,
	input  mbht_pkg::ent_t               dn_ent,
	input  wire                          dn_vld,
	input  wire                          seen_in,
	output logic                         seen_out,
	input  wire                          found_in,
	output logic                         found_out,
	input  mbht_pkg::ent_t               sel_in,
	output mbht_pkg::ent_t               sel_out,
	output mbht_pkg::ent_t               ent,
	output logic                         vld,
	output logic                         match,
	output mbht_pkg::ent_t               ent_nxt,
	output logic                         vld_nxt
);
	import mbht_pkg::*;

	ent_t ent_q;
	logic vld_q;
	logic match_q;

	// seen runs from the top down, found and the selected entry run upwards
	assign seen_out  = seen_in | match_q;
	assign found_out = found_in | match_q;
	assign sel_out   = ent_t'(sel_in | (match_q ? ent_q : ent_t'('0)));

	always_comb begin
		ent_nxt = ent_q;
		vld_nxt = vld_q;
		if (ctl.en) begin
			if (ctl.clear_all) begin
				ent_nxt = '0;
				vld_nxt = 1'b0;
			end else if (ctl.act) begin
				if (IDX == 0) begin
					ent_nxt = head;
					vld_nxt = 1'b1;
				end else if ((ctl.hit && (match_q || found_in)) || (!ctl.hit && !ctl.full)) begin
					ent_nxt = up_ent;
					vld_nxt = up_vld;
				end
			end else if (ctl.drop_top || (ctl.drop_hit && (seen_in || match_q))) begin
				ent_nxt = dn_ent;
				vld_nxt = dn_vld;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q   <= 1'b0;
			match_q <= 1'b0;
		end else begin
			vld_q <= vld_nxt;
			if (cmp_load) begin
				match_q <= vld_q && (ent_q.addr == cmp_addr);
			end
		end
	end

	always_ff @(posedge clk) begin
		ent_q <= ent_nxt;
	end

	assign ent   = ent_q;
	assign vld   = vld_q;
	assign match = match_q;

endmodule

`default_nettype wire

// ===== rtl/mru_bonded_host_table_top.sv =====
// Most-recently-used table of bonded peers built as a chain of TABLE_DEPTH cells.
// Each command is handled in a compare step and an update step: when it is accepted every cell compares
// its stored address with the command address and registers the match; then, once
// the output register is free, the chain shifts (move to front, insert, close a gap)
// and the result is loaded into the output register. The next command is accepted
// once that update is done, so a new command cannot enter while one is in the
// update step; a result left waiting holds back the update of the next command.
// depends on mbht_pkg, mbht_cmd_if, mbht_rsp_if, mbht_cell
`timescale 1ns / 1ps
`default_nettype none

module mru_bonded_host_table_top #(
	parameter int TABLE_DEPTH = mbht_pkg::DEF_TABLE_DEPTH
) (
	input  wire        clk,
	input  wire        arst_n,
	mbht_cmd_if.sink   cmd,
	mbht_rsp_if.source rsp
);
	import mbht_pkg::*;

	localparam int CW = $clog2(TABLE_DEPTH + 1);

	// command held for the update cycle
	logic              s1_valid_q;
	logic [2:0]        cmd_s1;
	logic [ADDR_W-1:0] addr_s1;
	logic              has_key_s1;
	logic [1:0]        tr_s1;
	logic [1:0]        at_s1;
	logic [FLAG_W-1:0] nf_s1;
	logic [FLAG_W-1:0] inf_s1;

	logic [CW-1:0] count_q;
	logic [CW-1:0] count_nxt;

	logic               out_valid_q;
	logic               was_present_q;
	logic               top_changed_q;
	logic               op_ok_q;
	logic [FLAG_W-1:0]  nf_out_q;
	logic [FLAG_W-1:0]  inf_out_q;
	logic [TOTAL_W-1:0] total_q;
	logic [ADDR_W-1:0]  act_addr_q;
	logic [1:0]         act_tr_q;
	logic [1:0]         act_at_q;

	logic accept;
	logic fire;
	logic hit;
	logic full;
	logic ok;
	logic [FLAG_W-1:0] nf_out;
	logic [FLAG_W-1:0] inf_out;

	cell_ctl_t ctl;
	ent_t      head;
	ent_t      top_nxt;
	logic      top_vld_nxt;

	ent_t ent_pad [0:TABLE_DEPTH+1];
	logic vld_pad [0:TABLE_DEPTH+1];
	ent_t ent_nxt_w [0:TABLE_DEPTH-1];
	logic vld_nxt_w [0:TABLE_DEPTH-1];
	logic seen_w  [0:TABLE_DEPTH];
	logic found_w [0:TABLE_DEPTH];
	ent_t sel_w   [0:TABLE_DEPTH];
	logic [TABLE_DEPTH-1:0] match_vec;
	logic [TABLE_DEPTH-1:0] vld_vec;

	assign accept    = cmd.valid && cmd.ready;
	assign cmd.ready = !s1_valid_q;
	assign fire      = s1_valid_q && (!out_valid_q || rsp.ready);

	assign ent_pad[0]               = '0;
	assign vld_pad[0]               = 1'b0;
	assign ent_pad[TABLE_DEPTH + 1] = '0;
	assign vld_pad[TABLE_DEPTH + 1] = 1'b0;
	assign seen_w[0]                = 1'b0;
	assign found_w[TABLE_DEPTH]     = 1'b0;
	assign sel_w[TABLE_DEPTH]       = '0;

	for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
		mbht_cell #(
			.IDX (i)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.cmp_load  (accept),
			.cmp_addr  (cmd.peer_address),
			.ctl       (ctl),
			.head      (head),
			.up_ent    (ent_pad[i]),
			.up_vld    (vld_pad[i]),
			.dn_ent    (ent_pad[i + 2]),
			.dn_vld    (vld_pad[i + 2]),
			.seen_in   (seen_w[i]),
			.seen_out  (seen_w[i + 1]),
			.found_in  (found_w[i + 1]),
			.found_out (found_w[i]),
			.sel_in    (sel_w[i + 1]),
			.sel_out   (sel_w[i]),
			.ent       (ent_pad[i + 1]),
			.vld       (vld_pad[i + 1]),
			.match     (match_vec[i]),
			.ent_nxt   (ent_nxt_w[i]),
			.vld_nxt   (vld_nxt_w[i])
		);
		assign vld_vec[i] = vld_pad[i + 1];
	end

	assign hit         = found_w[0];
	assign full        = (count_q == CW'(TABLE_DEPTH));
	assign top_nxt     = ent_nxt_w[0];
	assign top_vld_nxt = vld_nxt_w[0];

	// new top entry for the activating commands
	always_comb begin
		head = sel_w[0];
		if (!hit) begin
			head      = '0;
			head.addr = addr_s1;
			head.tr   = TR_LE;
		end
		case (cmd_code_t'(cmd_s1))
			CMD_SET_KEY: begin
				if (has_key_s1) begin
					head.tr = (tr_s1 == TR_BREDR) ? TR_BREDR : TR_LE;
					head.at = at_s1;
				end
			end
			CMD_SET_FLAGS: begin
				if (head.tr == TR_LE) begin
					head.nf  = nf_s1;
					head.inf = inf_s1;
				end
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		ctl           = '0;
		ctl.en        = fire;
		ctl.hit       = hit;
		ctl.full      = full;
		count_nxt     = count_q;
		ok            = 1'b0;
		nf_out        = '0;
		inf_out       = '0;
		case (cmd_code_t'(cmd_s1))
			CMD_SET_KEY, CMD_SET_FLAGS, CMD_GET_FLAGS: begin
				ctl.act = 1'b1;
				if (!hit && !full) begin
					count_nxt = count_q + CW'(1);
				end
				if ((cmd_code_t'(cmd_s1) == CMD_GET_FLAGS) && (head.tr == TR_LE)) begin
					ok      = 1'b1;
					nf_out  = head.nf;
					inf_out = head.inf;
				end
			end
			CMD_REMOVE_ACT: begin
				if (count_q != '0) begin
					ctl.drop_top = 1'b1;
					count_nxt    = count_q - CW'(1);
					ok           = 1'b1;
				end
			end
			CMD_REMOVE_ADDR: begin
				ctl.drop_hit = 1'b1;
				if (hit) begin
					count_nxt = count_q - CW'(1);
					ok        = 1'b1;
				end
			end
			CMD_REMOVE_ALL: begin
				ctl.clear_all = 1'b1;
				count_nxt     = '0;
				ok            = (count_q != '0);
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q  <= 1'b0;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				s1_valid_q <= 1'b1;
			end else if (fire) begin
				s1_valid_q <= 1'b0;
			end
			if (fire) begin
				count_q     <= count_nxt;
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1     <= cmd.command;
			addr_s1    <= cmd.peer_address;
			has_key_s1 <= cmd.has_key;
			tr_s1      <= cmd.link_transport;
			at_s1      <= cmd.peer_addr_type;
			nf_s1      <= cmd.notify_flags_in;
			inf_s1     <= cmd.indicate_flags_in;
		end
		if (fire) begin
			was_present_q <= hit;
			top_changed_q <= ctl.act && !match_vec[0];
			op_ok_q       <= ok;
			nf_out_q      <= nf_out;
			inf_out_q     <= inf_out;
			total_q       <= TOTAL_W'(count_nxt);
			if (top_vld_nxt) begin
				act_addr_q <= top_nxt.addr;
				act_tr_q   <= top_nxt.tr;
				act_at_q   <= (top_nxt.tr == TR_LE) ? top_nxt.at : 2'd0;
			end else begin
				act_addr_q <= '0;
				act_tr_q   <= TR_NONE;
				act_at_q   <= 2'd0;
			end
		end
	end

	assign rsp.valid              = out_valid_q;
	assign rsp.was_present        = was_present_q;
	assign rsp.top_changed        = top_changed_q;
	assign rsp.op_ok              = op_ok_q;
	assign rsp.notify_flags_out   = nf_out_q;
	assign rsp.indicate_flags_out = inf_out_q;
	assign rsp.entry_total        = total_q;
	assign rsp.active_address     = act_addr_q;
	assign rsp.active_transport   = act_tr_q;
	assign rsp.active_addr_type   = act_at_q;

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(TABLE_DEPTH))
		else $error("entry count beyond table depth");

	a_count_matches_valid: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(vld_vec) == int'(count_q))
		else $error("valid cells disagree with entry count");

	a_single_match: assert property (@(posedge clk) disable iff (!arst_n)
		s1_valid_q |-> $onehot0(match_vec))
		else $error("address stored in more than one cell");

	a_clear_all: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && (cmd_s1 == CMD_REMOVE_ALL)) |=> (count_q == '0) && (vld_vec == '0))
		else $error("table not empty after remove all");

	a_update_frees_input: assert property (@(posedge clk) disable iff (!arst_n)
		fire |=> cmd.ready && rsp.valid)
		else $error("update did not release the command stage");

endmodule

`default_nettype wire

// ===== tb/sv/mru_bonded_host_table_top_tb.sv =====
// mru_bonded_host_table_top_tb: self-checking bench for the bonded host table
// predicts each result from its own move-to-front table and compares field by field
// depends on mbht_pkg, mbht_cmd_if, mbht_rsp_if and mru_bonded_host_table_top
`timescale 1ns / 1ps

module mru_bonded_host_table_top_tb;
	import mbht_pkg::*;

	localparam int TABLE_DEPTH = DEF_TABLE_DEPTH;
	localparam int POOL_SIZE   = 14;
	localparam int PHASE_ITEMS = 225;
	localparam logic [1:0] TR_ODD = 2'd3;

	typedef struct packed {
		logic [2:0]        command;
		logic [ADDR_W-1:0] peer_address;
		logic              has_key;
		logic [1:0]        link_transport;
		logic [1:0]        peer_addr_type;
		logic [FLAG_W-1:0] notify_flags;
		logic [FLAG_W-1:0] indicate_flags;
	} cmd_item_t;

	typedef struct packed {
		logic               was_present;
		logic               top_changed;
		logic               op_ok;
		logic [FLAG_W-1:0]  notify_flags;
		logic [FLAG_W-1:0]  indicate_flags;
		logic [TOTAL_W-1:0] entry_total;
		logic [ADDR_W-1:0]  active_address;
		logic [1:0]         active_transport;
		logic [1:0]         active_addr_type;
	} reply_t;

	class host_table_checker;
		ent_t        slots [TABLE_DEPTH];
		int unsigned used;
		reply_t      pending_replies [$];
		int unsigned mismatches;
		int unsigned replies_checked;
		int unsigned full_overwrites;
		int unsigned cmd_tally [8];

		function new();
			foreach (slots[i]) slots[i] = '0;
			foreach (cmd_tally[i]) cmd_tally[i] = 0;
			used = 0;
			mismatches = 0;
			replies_checked = 0;
			full_overwrites = 0;
		endfunction

		task report_mismatch(string msg);
			mismatches++;
			$display("%0t mismatch: %s", $realtime, msg);
		endtask

		function bit locate(logic [ADDR_W-1:0] a, output int unsigned idx);
			idx = 0;
			for (int unsigned i = 0; i < used && i < TABLE_DEPTH; i++) begin
				if (slots[i].addr == a) begin
					idx = i;
					return 1'b1;
				end
			end
			return 1'b0;
		endfunction

		// close the gap and clear the freed slot
		function void drop_at(int unsigned i);
			if (i >= used)
				return;
			for (int unsigned j = i; j + 1 < used; j++)
				slots[j] = slots[j + 1];
			used--;
			slots[used] = '0;
		endfunction

		function void shift_down();
			for (int unsigned j = used; j > 0; j--)
				slots[j] = slots[j - 1];
			used++;
		endfunction

		function bit bring_to_top(logic [ADDR_W-1:0] a);
			int unsigned idx;
			ent_t        keep;
			if (locate(a, idx)) begin
				if (idx == 0)
					return 1'b0;
				keep = slots[idx];
				drop_at(idx);
				shift_down();
				slots[0] = keep;
				return 1'b1;
			end
			// a full table loses its top entry to the newcomer
			if (used < TABLE_DEPTH)
				shift_down();
			else
				full_overwrites++;
			slots[0] = '0;
			slots[0].addr = a;
			slots[0].tr = TR_LE;
			return 1'b1;
		endfunction

		function void note_command(cmd_item_t c);
			reply_t      r;
			int unsigned idx;
			r = '0;
			cmd_tally[c.command]++;
			r.was_present = locate(c.peer_address, idx);
			case (c.command)
				CMD_SET_KEY: begin
					r.top_changed = bring_to_top(c.peer_address);
					if (c.has_key) begin
						slots[0].tr = (c.link_transport == TR_BREDR) ? TR_BREDR : TR_LE;
						slots[0].at = c.peer_addr_type;
					end
				end
				CMD_SET_FLAGS: begin
					r.top_changed = bring_to_top(c.peer_address);
					if (slots[0].tr == TR_LE) begin
						slots[0].nf = c.notify_flags;
						slots[0].inf = c.indicate_flags;
					end
				end
				CMD_GET_FLAGS: begin
					r.top_changed = bring_to_top(c.peer_address);
					if (used > 0 && slots[0].tr == TR_LE) begin
						r.op_ok = 1'b1;
						r.notify_flags = slots[0].nf;
						r.indicate_flags = slots[0].inf;
					end
				end
				CMD_REMOVE_ACT: begin
					if (used > 0) begin
						drop_at(0);
						r.op_ok = 1'b1;
					end
				end
				CMD_REMOVE_ADDR: begin
					if (locate(c.peer_address, idx)) begin
						drop_at(idx);
						r.op_ok = 1'b1;
					end
				end
				CMD_REMOVE_ALL: begin
					r.op_ok = (used > 0);
					foreach (slots[i]) slots[i] = '0;
					used = 0;
				end
				default: ;
			endcase
			r.entry_total = used[TOTAL_W-1:0];
			if (used > 0) begin
				r.active_address = slots[0].addr;
				r.active_transport = slots[0].tr;
				r.active_addr_type = (slots[0].tr == TR_LE) ? slots[0].at : 2'b00;
			end
			pending_replies.push_back(r);
		endfunction

		task compare_field(string name, logic [63:0] got, logic [63:0] want);
			if (got !== want)
				report_mismatch($sformatf("result %0d %s: got %0h, expected %0h",
					replies_checked, name, got, want));
		endtask

		task check_reply(reply_t got);
			reply_t want;
			if (pending_replies.size() == 0) begin
				report_mismatch("result transaction with nothing expected");
				return;
			end
			want = pending_replies.pop_front();
			replies_checked++;
			compare_field("was_present", 64'(got.was_present), 64'(want.was_present));
			compare_field("top_changed", 64'(got.top_changed), 64'(want.top_changed));
			compare_field("op_ok", 64'(got.op_ok), 64'(want.op_ok));
			compare_field("notify_flags_out", 64'(got.notify_flags),
				64'(want.notify_flags));
			compare_field("indicate_flags_out", 64'(got.indicate_flags),
				64'(want.indicate_flags));
			compare_field("entry_total", 64'(got.entry_total), 64'(want.entry_total));
			compare_field("active_address", 64'(got.active_address),
				64'(want.active_address));
			compare_field("active_transport", 64'(got.active_transport),
				64'(want.active_transport));
			compare_field("active_addr_type", 64'(got.active_addr_type),
				64'(want.active_addr_type));
		endtask
	endclass

	logic clk;
	logic arst_n;
	int   stall_pct;

	logic [ADDR_W-1:0] addr_pool [POOL_SIZE];
	host_table_checker sb;

	mbht_cmd_if cmd_bus ();
	mbht_rsp_if rsp_bus ();

	mru_bonded_host_table_top dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd_bus),
		.rsp    (rsp_bus)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		rsp_bus.ready <= ($urandom_range(99) >= stall_pct);
	end

	// result first: it always belongs to an earlier command
	always @(posedge clk) begin
		if (arst_n) begin
			if (rsp_bus.valid && rsp_bus.ready)
				sb.check_reply('{rsp_bus.was_present, rsp_bus.top_changed, rsp_bus.op_ok,
					rsp_bus.notify_flags_out, rsp_bus.indicate_flags_out,
					rsp_bus.entry_total, rsp_bus.active_address,
					rsp_bus.active_transport, rsp_bus.active_addr_type});
			if (cmd_bus.valid && cmd_bus.ready)
				sb.note_command('{cmd_bus.command, cmd_bus.peer_address, cmd_bus.has_key,
					cmd_bus.link_transport, cmd_bus.peer_addr_type,
					cmd_bus.notify_flags_in, cmd_bus.indicate_flags_in});
		end
	end

	function automatic cmd_item_t make_cmd(cmd_code_t op, logic [ADDR_W-1:0] a, logic key,
			logic [1:0] tr, logic [1:0] at, logic [FLAG_W-1:0] nf, logic [FLAG_W-1:0] inf);
		cmd_item_t c;
		c = '{op, a, key, tr, at, nf, inf};
		return c;
	endfunction

	task automatic drive_command(input cmd_item_t item, input int idle_pct);
		if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
			cmd_bus.valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		cmd_bus.valid             <= 1'b1;
		cmd_bus.command           <= item.command;
		cmd_bus.peer_address      <= item.peer_address;
		cmd_bus.has_key           <= item.has_key;
		cmd_bus.link_transport    <= item.link_transport;
		cmd_bus.peer_addr_type    <= item.peer_addr_type;
		cmd_bus.notify_flags_in   <= item.notify_flags;
		cmd_bus.indicate_flags_in <= item.indicate_flags;
		do @(posedge clk); while (!cmd_bus.ready);
	endtask

	// hold the sender until every result is back
	task automatic wait_drained();
		cmd_bus.valid <= 1'b0;
		do @(posedge clk); while (sb.pending_replies.size() != 0);
	endtask

	task automatic run_phase(input int idle_pct, input int stall);
		cmd_item_t   c;
		int unsigned pick;
		logic [63:0] rnd64;
		stall_pct = stall;
		for (int n = 0; n < PHASE_ITEMS; n++) begin
			pick = $urandom_range(99);
			if (pick < 24)
				c.command = CMD_SET_KEY;
			else if (pick < 42)
				c.command = CMD_SET_FLAGS;
			else if (pick < 62)
				c.command = CMD_GET_FLAGS;
			else if (pick < 70)
				c.command = CMD_REMOVE_ACT;
			else if (pick < 82)
				c.command = CMD_REMOVE_ADDR;
			else if (pick < 85)
				c.command = CMD_REMOVE_ALL;
			else
				c.command = CMD_QUERY;
			// a pool larger than the table gives hits, misses and full-table inserts
			rnd64 = {$urandom, $urandom};
			if ($urandom_range(99) < 85)
				c.peer_address = addr_pool[$urandom_range(POOL_SIZE - 1)];
			else
				c.peer_address = rnd64[ADDR_W-1:0];
			c.has_key = 1'($urandom_range(1));
			c.link_transport = ($urandom_range(1) != 0) ? TR_BREDR : TR_LE;
			c.peer_addr_type = 2'($urandom_range(3));
			pick = $urandom_range(9);
			c.notify_flags = (pick == 0) ? '0 : (pick == 1) ? '1 : FLAG_W'($urandom);
			pick = $urandom_range(9);
			c.indicate_flags = (pick == 0) ? '0 : (pick == 1) ? '1 : FLAG_W'($urandom);
			drive_command(c, idle_pct);
		end
		wait_drained();
	endtask

	initial begin
		logic [63:0] rnd64;
		clk = 1'b0;
		arst_n = 1'b0;
		stall_pct = 0;
		rsp_bus.ready = 1'b0;
		cmd_bus.valid = 1'b0;
		cmd_bus.command = CMD_QUERY;
		cmd_bus.peer_address = '0;
		cmd_bus.has_key = 1'b0;
		cmd_bus.link_transport = TR_LE;
		cmd_bus.peer_addr_type = 2'b00;
		cmd_bus.notify_flags_in = '0;
		cmd_bus.indicate_flags_in = '0;
		sb = new();
		addr_pool[0] = '0;
		addr_pool[1] = '1;
		for (int i = 2; i < POOL_SIZE; i++) begin
			rnd64 = {$urandom, $urandom};
			addr_pool[i] = rnd64[ADDR_W-1:0];
		end

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty table, transports, flag extremes, removals, overflow
		drive_command(make_cmd(CMD_QUERY, 48'h0, 1'b0, TR_LE, 2'd0, '0, '0), 0);
		drive_command(make_cmd(CMD_REMOVE_ACT, 48'h0, 1'b0, TR_LE, 2'd0, '0, '0), 0);
		drive_command(make_cmd(CMD_REMOVE_ALL, 48'h0, 1'b0, TR_LE, 2'd0, '0, '0), 0);
		drive_command(make_cmd(CMD_GET_FLAGS, 48'h1234_5678_9abc, 1'b0, TR_LE, 2'd0, '0, '0),
			0);
		drive_command(make_cmd(CMD_SET_KEY, 48'hffff_ffff_ffff, 1'b1, TR_BREDR, 2'd3, '0, '0),
			0);
		drive_command(make_cmd(CMD_SET_FLAGS, 48'hffff_ffff_ffff, 1'b0, TR_LE, 2'd0, '1, '1),
			0);
		drive_command(make_cmd(CMD_GET_FLAGS, 48'hffff_ffff_ffff, 1'b0, TR_LE, 2'd0, '0, '0),
			0);
		drive_command(make_cmd(CMD_SET_KEY, 48'h0, 1'b0, TR_BREDR, 2'd3, '0, '0), 0);
		drive_command(make_cmd(CMD_SET_FLAGS, 48'h0, 1'b0, TR_LE, 2'd0, '1, '1), 0);
		drive_command(make_cmd(CMD_GET_FLAGS, 48'h0, 1'b0, TR_LE, 2'd0, '0, '0), 0);
		drive_command(make_cmd(CMD_SET_KEY, 48'ha5a5_5a5a_0f0f, 1'b1, TR_NONE, 2'd3, '0, '0),
			0);
		drive_command(make_cmd(CMD_SET_KEY, 48'h5a5a_a5a5_f0f0, 1'b1, TR_ODD, 2'd1, '0, '0),
			0);
		drive_command(make_cmd(CMD_REMOVE_ADDR, 48'h0000_0000_0001, 1'b0, TR_LE, 2'd0, '0,
			'0), 0);
		drive_command(make_cmd(CMD_REMOVE_ADDR, 48'hffff_ffff_ffff, 1'b0, TR_LE, 2'd0, '0,
			'0), 0);
		for (int i = 0; i < 6; i++) begin
			rnd64 = {$urandom, $urandom};
			drive_command(make_cmd(CMD_SET_KEY, rnd64[ADDR_W-1:0], 1'b1, TR_LE, 2'd2,
				'0, '0), 0);
		end
		drive_command(make_cmd(CMD_REMOVE_ACT, 48'h0, 1'b0, TR_LE, 2'd0, '0, '0), 0);
		drive_command(make_cmd(CMD_GET_FLAGS, 48'h0, 1'b0, TR_LE, 2'd0, '0, '0), 0);
		drive_command(make_cmd(CMD_REMOVE_ALL, 48'h0, 1'b0, TR_LE, 2'd0, '0, '0), 0);
		drive_command(make_cmd(CMD_QUERY, 48'hffff_ffff_ffff, 1'b0, TR_LE, 2'd0, '0, '0), 0);
		wait_drained();

		run_phase(0, 0);
		run_phase(67, 0);
		run_phase(0, 67);
		run_phase(32, 32);

		// let any stray result transaction show up
		repeat (10) @(posedge clk);
		if (sb.pending_replies.size() != 0)
			sb.report_mismatch($sformatf("%0d results never arrived",
				sb.pending_replies.size()));

		$display("commands: %0d set key, %0d set flags, %0d get flags, %0d remove active,",
			sb.cmd_tally[CMD_SET_KEY], sb.cmd_tally[CMD_SET_FLAGS],
			sb.cmd_tally[CMD_GET_FLAGS], sb.cmd_tally[CMD_REMOVE_ACT]);
		$display("  %0d remove by address, %0d remove all, %0d query; %0d results, %s",
			sb.cmd_tally[CMD_REMOVE_ADDR], sb.cmd_tally[CMD_REMOVE_ALL],
			sb.cmd_tally[CMD_QUERY], sb.replies_checked,
			$sformatf("%0d full inserts", sb.full_overwrites));
		if (sb.mismatches == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

	initial begin
		#2ms;
		$display("timeout with %0d results outstanding", sb.pending_replies.size());
		$display("end of test: mismatches");
		$finish;
	end

endmodule
